>>> hdl/cdisp_pkg.sv
// ----------------------------------------------------------------------------
// cdisp_pkg: shared types and constants of the card dispenser controller
// Item payloads, controller state record and register reset value.
// ----------------------------------------------------------------------------
package cdisp_pkg;

  // Reset value of the jam timeout register, in ticks
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  // One input item: the three signals sampled on one tick
  typedef struct packed {
    logic game_over_active;
    logic clear_request_active;
    logic card_sensor_active;
  } cdisp_in_t;

  // One result item: output drives after the tick
  typedef struct packed {
    logic motor_run;
    logic alert_on;
    logic jam_error;
    logic card_pending;
  } cdisp_out_t;

  // Controller state apart from the sample histories
  typedef struct packed {
    logic        pending;
    logic [15:0] ticks;
    logic        error;
    logic        motor;
    logic        alert;
  } cdisp_state_t;

endpackage

>>> hdl/card_dispenser_controller.sv
// ----------------------------------------------------------------------------
// card_dispenser_controller: tick-driven card dispenser control
// Path: an accepted item passes through the input register, then the result
//   register. Throughput: one item per cycle, held back only when both
//   registers are full and out_ready is low.
// Reset: synchronous, active low; clears histories and state, sets the
//   timeout register to 2000 ticks.
// ----------------------------------------------------------------------------
module card_dispenser_controller #(
  parameter int HISTORY_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cdisp_pkg::cdisp_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cdisp_pkg::cdisp_out_t out_data,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata
);

  cdisp_pkg::cdisp_in_t    in_r;
  logic                    s1_valid_r;
  logic                    out_valid_r;
  cdisp_pkg::cdisp_out_t   out_data_r;
  logic [15:0]             timeout_r;
  logic [HISTORY_BITS-1:0] go_hist_r;
  logic [HISTORY_BITS-1:0] clr_hist_r;
  logic [HISTORY_BITS-1:0] sens_hist_r;
  cdisp_pkg::cdisp_state_t state_r;
  logic [HISTORY_BITS-1:0] go_hist_nxt;
  logic [HISTORY_BITS-1:0] clr_hist_nxt;
  logic [HISTORY_BITS-1:0] sens_hist_nxt;
  cdisp_pkg::cdisp_state_t state_nxt;
  logic                    out_free;
  logic                    s1_adv;

  // Pipeline flow control
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= cdisp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // Input register: capture the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  cdisp_step #(
    .HIST_BITS (HISTORY_BITS)
  ) u_step (
    .sample        (in_r),
    .go_hist       (go_hist_r),
    .clr_hist      (clr_hist_r),
    .sens_hist     (sens_hist_r),
    .state         (state_r),
    .limit         (timeout_r),
    .go_hist_nxt   (go_hist_nxt),
    .clr_hist_nxt  (clr_hist_nxt),
    .sens_hist_nxt (sens_hist_nxt),
    .state_nxt     (state_nxt)
  );

  // Commit state and result when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_hist_r   <= '0;
      clr_hist_r  <= '0;
      sens_hist_r <= '0;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        go_hist_r   <= go_hist_nxt;
        clr_hist_r  <= clr_hist_nxt;
        sens_hist_r <= sens_hist_nxt;
        state_r     <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.motor_run    <= state_nxt.motor;
      out_data_r.alert_on     <= state_nxt.alert;
      out_data_r.jam_error    <= state_nxt.error;
      out_data_r.card_pending <= state_nxt.pending;
    end
  end

endmodule

>>> hdl/cdisp_step.sv
// ----------------------------------------------------------------------------
// cdisp_step: next-state logic for one tick
// Shifts the sample histories, detects edge events and updates the dispense
// and jam error state.
// ----------------------------------------------------------------------------
module cdisp_step #(
  parameter int HIST_BITS = 8
) (
  input  cdisp_pkg::cdisp_in_t    sample,
  input  logic [HIST_BITS-1:0]    go_hist,
  input  logic [HIST_BITS-1:0]    clr_hist,
  input  logic [HIST_BITS-1:0]    sens_hist,
  input  cdisp_pkg::cdisp_state_t state,
  input  logic [15:0]             limit,
  output logic [HIST_BITS-1:0]    go_hist_nxt,
  output logic [HIST_BITS-1:0]    clr_hist_nxt,
  output logic [HIST_BITS-1:0]    sens_hist_nxt,
  output cdisp_pkg::cdisp_state_t state_nxt
);

  // Event pattern: newest half of samples active (0), older ones inactive (1)
  localparam int LOW_BITS = HIST_BITS / 2;
  localparam logic [HIST_BITS-1:0] EVENT_PAT =
    {{(HIST_BITS - LOW_BITS){1'b1}}, {LOW_BITS{1'b0}}};

  logic [HIST_BITS-1:0] clr_once;
  logic [HIST_BITS-1:0] clr_twice;
  logic [HIST_BITS-1:0] sens_shift;
  logic [15:0]          ticks_inc;
  logic                 go_event;
  logic                 clr_event;
  logic                 sens_event;
  logic                 error_mid;
  logic                 alert_mid;
  logic                 pending_mid;
  logic                 dispensing;
  logic [15:0]          ticks_mid;

  // Shift samples in; a history bit of 1 marks an inactive sample
  assign go_hist_nxt = {go_hist[HIST_BITS-2:0], ~sample.game_over_active};
  assign clr_once    = {clr_hist[HIST_BITS-2:0], ~sample.clear_request_active};
  assign clr_twice   = {clr_once[HIST_BITS-2:0], ~sample.clear_request_active};
  assign sens_shift  = {sens_hist[HIST_BITS-2:0], ~sample.card_sensor_active};

  assign go_event   = (go_hist_nxt == EVENT_PAT);
  assign clr_event  = state.error && (clr_twice == EVENT_PAT);
  assign sens_event = (sens_shift == EVENT_PAT);

  // Second clear shift only while in error
  assign clr_hist_nxt = state.error ? clr_twice : clr_once;

  // Clear event drops the error before the dispense step
  assign error_mid   = state.error && !clr_event;
  assign alert_mid   = state.alert && !clr_event;
  assign pending_mid = state.pending || go_event;
  assign dispensing  = !error_mid && pending_mid;

  assign ticks_inc = state.ticks + 16'd1;
  assign ticks_mid = sens_event ? 16'd0 : ticks_inc;

  // Sensor history advances only on dispensing ticks
  assign sens_hist_nxt = dispensing ? sens_shift : sens_hist;

  // Dispense step, sensor stop, then jam timeout check
  always_comb begin
    state_nxt.pending = pending_mid;
    state_nxt.ticks   = state.ticks;
    state_nxt.error   = error_mid;
    state_nxt.motor   = state.motor;
    state_nxt.alert   = alert_mid;
    if (dispensing) begin
      state_nxt.ticks = ticks_mid;
      state_nxt.motor = !sens_event;
      if (sens_event) begin
        state_nxt.pending = 1'b0;
      end
      if (ticks_mid >= limit) begin
        state_nxt.motor = 1'b0;
        state_nxt.alert = 1'b1;
        state_nxt.ticks = 16'd0;
        state_nxt.error = 1'b1;
      end
    end
  end

endmodule

>>> hdl/cdisp_checker.sv
// ----------------------------------------------------------------------------
// cdisp_checker: port-level checks of the card dispenser controller
// Watches the result channel for consistent drive states and a held result.
// ----------------------------------------------------------------------------
module cdisp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input cdisp_pkg::cdisp_out_t out_data
);

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // Jam error: motor stopped and alert lit
  a_jam_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.jam_error |-> !out_data.motor_run && out_data.alert_on)
    else $error("jam error without stopped motor and lit alert");

  // Motor only runs for a pending card
  a_motor_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.motor_run |-> out_data.card_pending)
    else $error("motor running with no card pending");

  // Stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Input stays open when the result side drains every cycle
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready && $past(out_ready) |-> in_ready)
    else $error("input blocked while output drains");

endmodule

bind card_dispenser_controller cdisp_checker u_cdisp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> test/cdisp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cdisp_tb_checker: result predictor and comparator for the card dispenser
// Watches the tick, result and register ports. Each accepted tick is run
// through a local model of the controller. Each accepted result is checked,
// field by field, against the oldest predicted output drive.
// ----------------------------------------------------------------------------
module cdisp_tb_checker #(
  parameter int HISTORY_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  cdisp_pkg::cdisp_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  cdisp_pkg::cdisp_out_t out_data,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  output int                    fail_count,
  output int                    results_due
);

  // History that marks an event: older half inactive (1), newer half active (0)
  localparam logic [HISTORY_BITS-1:0] EVENT_PAT =
    {{(HISTORY_BITS - HISTORY_BITS / 2){1'b1}}, {(HISTORY_BITS / 2){1'b0}}};

  // Model state of the controller
  logic [HISTORY_BITS-1:0] go_hist;
  logic [HISTORY_BITS-1:0] clr_hist;
  logic [HISTORY_BITS-1:0] sens_hist;
  logic                    card_wait;
  logic [15:0]             tick_count;
  logic                    jammed;
  logic                    motor;
  logic                    lamp;
  logic [15:0]             jam_limit;

  cdisp_pkg::cdisp_out_t expected_drives[$];
  int                    mismatches;

  string field_name[4] = '{"card_pending", "jam_error", "alert_on", "motor_run"};

  // Advance the model by one tick and return the drives after it
  function automatic cdisp_pkg::cdisp_out_t predict_tick(input cdisp_pkg::cdisp_in_t s);
    begin
      go_hist = {go_hist[HISTORY_BITS-2:0], ~s.game_over_active};
      if (go_hist == EVENT_PAT) card_wait = 1'b1;

      // The clear history shifts a second time while jammed; only that shift counts
      clr_hist = {clr_hist[HISTORY_BITS-2:0], ~s.clear_request_active};
      if (jammed) begin
        clr_hist = {clr_hist[HISTORY_BITS-2:0], ~s.clear_request_active};
        if (clr_hist == EVENT_PAT) begin
          jammed = 1'b0;
          lamp   = 1'b0;
        end
      end

      // Dispense: run the motor, count ticks, watch the card sensor
      if (!jammed && card_wait) begin
        tick_count = tick_count + 16'd1;
        motor      = 1'b1;
        sens_hist  = {sens_hist[HISTORY_BITS-2:0], ~s.card_sensor_active};
        if (sens_hist == EVENT_PAT) begin
          card_wait  = 1'b0;
          tick_count = '0;
          motor      = 1'b0;
        end
        if (tick_count >= jam_limit) begin
          motor      = 1'b0;
          lamp       = 1'b1;
          tick_count = '0;
          jammed     = 1'b1;
        end
      end

      predict_tick = {motor, lamp, jammed, card_wait};
    end
  endfunction

  // Track register writes, check results, predict accepted ticks
  always @(posedge clk) begin : watch
    logic [3:0] want;
    logic [3:0] got;
    if (!rst_n) begin
      go_hist    = '0;
      clr_hist   = '0;
      sens_hist  = '0;
      card_wait  = 1'b0;
      tick_count = '0;
      jammed     = 1'b0;
      motor      = 1'b0;
      lamp       = 1'b0;
      jam_limit  = cdisp_pkg::TIMEOUT_RESET;
      mismatches = 0;
      expected_drives.delete();
    end else begin
      if (cfg_we) jam_limit = cfg_wdata;

      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          $display("%0t: result %b arrived with nothing expected", $time, out_data);
          mismatches++;
        end else begin
          want = expected_drives.pop_front();
          got  = out_data;
          for (int k = 3; k >= 0; k--) begin
            if (got[k] !== want[k]) begin
              $display("%0t: %s expected %0b got %0b", $time, field_name[k],
                       want[k], got[k]);
              mismatches++;
            end
          end
        end
      end

      if (in_valid && in_ready) expected_drives.push_back(predict_tick(in_data));
    end
    fail_count  <= mismatches;
    results_due <= expected_drives.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the card dispenser controller
// Drives sensor ticks as runs of asserted and released samples so that
// game-over, card-out and clear events happen often, over a range of jam
// timeouts, with random gaps on both channels. The checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TICKS_PER_PHASE = 115;
  localparam int CYCLE_LIMIT     = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  cdisp_pkg::cdisp_in_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  cdisp_pkg::cdisp_out_t out_data;
  logic                  cfg_we;
  logic [15:0]           cfg_wdata;

  int fail_count;
  int results_due;
  int cycles;
  bit gaps_on;

  // Current level and remaining run length of each sampled signal
  logic [2:0] run_level;
  int         run_left[3];

  card_dispenser_controller uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cdisp_tb_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random while gaps are enabled
  always @(posedge clk) begin
    out_ready <= !(gaps_on && $urandom_range(0, 99) < 31);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Offer one tick, with a random gap first, and hold it until accepted
  task automatic send_tick(input cdisp_pkg::cdisp_in_t s);
    while (gaps_on && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic tick(input logic go, input logic clr, input logic sens);
    send_tick({go, clr, sens});
  endtask

  // Hold off until every predicted result has been seen
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Next tick: each signal toggles in runs, mostly long enough for an event
  function automatic cdisp_pkg::cdisp_in_t next_sample();
    logic [2:0] s;
    begin
      for (int k = 0; k < 3; k++) begin
        if (run_left[k] == 0) begin
          run_level[k] = ~run_level[k];
          run_left[k]  = ($urandom_range(0, 9) < 7) ? $urandom_range(4, 8)
                                                    : $urandom_range(1, 3);
        end
        run_left[k]--;
      end
      s = run_level;
      if ($urandom_range(0, 99) < 12) s = 3'($urandom_range(0, 7));
      next_sample = s;
    end
  endfunction

  initial begin : stimulus
    int limits[8];
    limits    = '{1, 65535, 0, 5, 17, 2, 2000, 3};
    limits[5] = $urandom_range(2, 40);
    run_level = '0;
    for (int k = 0; k < 3; k++) run_left[k] = 0;
    gaps_on   = 1'b1;
    cycles    <= 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    out_ready <= 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short jam timeout: game-over event, jam, clear and resume in one tick
    set_limit(16'd2);
    tick(1'b1, 1'b1, 1'b1);
    repeat (4) tick(1'b0, 1'b0, 1'b0);
    repeat (4) tick(1'b1, 1'b0, 1'b0);
    repeat (2) tick(1'b1, 1'b0, 1'b1);
    repeat (2) tick(1'b0, 1'b1, 1'b1);
    repeat (4) tick(1'b0, 1'b0, 1'b0);
    repeat (4) tick(1'b1, 1'b1, 1'b1);
    drain();

    // Random phases over a spread of timeouts, both extremes included
    for (int p = 0; p < 8; p++) begin
      set_limit(limits[p][15:0]);
      gaps_on = (p != 3);
      for (int n = 0; n < TICKS_PER_PHASE; n++) send_tick(next_sample());
      drain();
    end

    gaps_on = 1'b1;
    if (fail_count == 0 && results_due == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
